/* rtl/tcsp_pkg.sv */
// ============================================================================
// tcsp_pkg
// shared types and constants for the truncated cone support point block
// ============================================================================
package tcsp_pkg;

    localparam int unsigned CFG_W   = 31;
    localparam int unsigned DIR_W   = 32;
    localparam int unsigned MAG_W   = 31;   // shifted magnitudes stay below 2^31
    localparam int unsigned SQ_W    = 64;   // A^2 + B^2
    localparam int unsigned ROOT_W  = 32;
    localparam int unsigned NUM_W   = 62;   // radius * A
    localparam int unsigned QUO_W   = 32;

    typedef enum logic [1:0] {
        REG_RADIUS_X    = 2'd0,
        REG_RADIUS_Z    = 2'd1,
        REG_HALF_HEIGHT = 2'd2,
        REG_RATIO       = 2'd3
    } t_reg_index;

endpackage

/* rtl/tcsp_divider.sv */
// ============================================================================
// tcsp_divider
// pipelined restoring divider, one quotient bit per stage, one request per cycle while i_en is high
// ============================================================================
module tcsp_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [tcsp_pkg::NUM_W-1:0]     i_num,
    input  logic [tcsp_pkg::ROOT_W-1:0]    i_den,
    output logic                           o_valid,
    output logic [tcsp_pkg::QUO_W-1:0]     o_quo
);
    localparam int unsigned N = tcsp_pkg::QUO_W;
    localparam int unsigned RW = tcsp_pkg::ROOT_W + 1;

    // quotient fits in 32 bits since radius*A/root <= radius < 2^31
    logic [N-1:0]                   r_v;
    logic [RW-1:0]                  r_rem [N];
    logic [tcsp_pkg::NUM_W-1:0]     r_num [N];
    logic [tcsp_pkg::ROOT_W-1:0]    r_den [N];
    logic [N-1:0]                   r_q   [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                           w_v;
        logic [RW-1:0]                  w_rem;
        logic [tcsp_pkg::NUM_W-1:0]     w_num;
        logic [tcsp_pkg::ROOT_W-1:0]    w_den;
        logic [N-1:0]                   w_q;
        logic [RW:0] n_trial;
        logic [RW:0] n_shift;
        if (k == 0) begin : g_src
            // numerator bits above the quotient width seed the remainder,
            // they stay below the divisor because the quotient fits
            assign w_v   = i_valid;
            assign w_rem = RW'(i_num[tcsp_pkg::NUM_W-1:N]);
            assign w_num = i_num;
            assign w_den = i_den;
            assign w_q   = '0;
        end else begin : g_src
            assign w_v   = r_v[k-1];
            assign w_rem = r_rem[k-1];
            assign w_num = r_num[k-1];
            assign w_den = r_den[k-1];
            assign w_q   = r_q[k-1];
        end
        always_comb begin
            // bring down next numerator bit
            n_shift = {w_rem, w_num[N-1-k]};
            n_trial = n_shift - {2'b00, w_den};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
            if (i_en) begin
                r_num[k] <= w_num;
                r_den[k] <= w_den;
                if (!n_trial[RW]) begin
                    r_rem[k] <= n_trial[RW-1:0];
                    r_q[k]   <= {w_q[N-2:0], 1'b1};
                end else begin
                    r_rem[k] <= n_shift[RW-1:0];
                    r_q[k]   <= {w_q[N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quo   = r_q[N-1];
endmodule

/* rtl/truncated_cone_support_point.sv */
// ============================================================================
// truncated_cone_support_point
// support point of a truncated elliptic cone for a search direction
// ============================================================================
// One request per cycle enters while the pipe advances, and each produces one
// result. The pipe is built from the 32-stage integer square root and the
// two 32-stage pipelined dividers that follow it, plus stages of scaling,
// top point and dot product compare. The whole pipe advances while the output
// register is empty or taken, so back pressure holds every stage in place.
module truncated_cone_support_point #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,    // dir_x, dir_y, dir_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,    // point_x, point_y, point_z
    output logic         m_axis_tuser     // on_top
);
    localparam int unsigned SQ_STEPS = 32;
    localparam int unsigned SQ_LAST  = SQ_STEPS - 1;
    localparam int unsigned DLY_LAST = tcsp_pkg::QUO_W - 1;

    logic [30:0] r_rx, r_rz, r_hh, r_ratio;
    logic        w_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx <= 31'd32768; r_rz <= 31'd32768;
            r_hh <= 31'd32768; r_ratio <= 31'd32768;
        end else if (i_cfg_we) begin
            unique case (tcsp_pkg::t_reg_index'(i_cfg_index))
                tcsp_pkg::REG_RADIUS_X:    r_rx    <= i_cfg_data;
                tcsp_pkg::REG_RADIUS_Z:    r_rz    <= i_cfg_data;
                tcsp_pkg::REG_HALF_HEIGHT: r_hh    <= i_cfg_data;
                tcsp_pkg::REG_RATIO:       r_ratio <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipe advances when output is free
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // side data carried beside the item
    typedef struct packed {
        logic        v;
        logic [31:0] dx, dy, dz;
    } t_side;

    // stage 1: magnitude products
    t_side       r1;
    logic [62:0] r1_ma, r1_mb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1.v <= 1'b0;
        else if (w_en) r1.v <= s_axis_tvalid;
        if (w_en) begin
            logic [31:0] mx, mz;
            mx = s_axis_tdata[31] ? -s_axis_tdata[31:0] : s_axis_tdata[31:0];
            mz = s_axis_tdata[95] ? -s_axis_tdata[95:64] : s_axis_tdata[95:64];
            r1.dx <= s_axis_tdata[31:0];
            r1.dy <= s_axis_tdata[63:32];
            r1.dz <= s_axis_tdata[95:64];
            r1_ma <= 63'(r_rx * mx);
            r1_mb <= 63'(r_rz * mz);
        end
    end

    // stage 2: common normalizing shift (at most 32, small priority search)
    t_side       r2;
    logic [30:0] r2_a, r2_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2.v <= 1'b0;
        else if (w_en) r2.v <= r1.v;
        if (w_en) begin
            logic [62:0] mx;
            logic [5:0]  s;
            mx = (r1_ma > r1_mb) ? r1_ma : r1_mb;
            s = '0;
            for (int k = 62; k >= 31; k--) begin
                if (mx[k] && s == 0) s = 6'(k - 30);
            end
            r2.dx <= r1.dx; r2.dy <= r1.dy; r2.dz <= r1.dz;
            r2_a <= 31'(r1_ma >> s);
            r2_b <= 31'(r1_mb >> s);
        end
    end

    // stage 3: sum of squares
    t_side       r3;
    logic [30:0] r3_a, r3_b;
    logic [63:0] r3_sq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3.v <= 1'b0;
        else if (w_en) r3.v <= r2.v;
        if (w_en) begin
            r3.dx <= r2.dx; r3.dy <= r2.dy; r3.dz <= r2.dz;
            r3_a <= r2_a; r3_b <= r2_b;
            r3_sq <= 64'(r2_a * r2_a) + 64'(r2_b * r2_b);
        end
    end

    // square root pipeline, one root bit per stage
    t_side       rs   [SQ_STEPS];
    logic [30:0] rs_a [SQ_STEPS];
    logic [30:0] rs_b [SQ_STEPS];
    logic [63:0] rs_x [SQ_STEPS];
    logic [63:0] rs_r [SQ_STEPS];
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        t_side       w_s;
        logic [30:0] w_a, w_b;
        logic [63:0] w_x, w_r;
        if (k == 0) begin : g_src
            assign w_s = r3;
            assign w_a = r3_a;
            assign w_b = r3_b;
            assign w_x = r3_sq;
            assign w_r = '0;
        end else begin : g_src
            assign w_s = rs[k-1];
            assign w_a = rs_a[k-1];
            assign w_b = rs_b[k-1];
            assign w_x = rs_x[k-1];
            assign w_r = rs_r[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rs[k].v <= 1'b0;
            else if (w_en) rs[k].v <= w_s.v;
            if (w_en) begin
                rs[k].dx <= w_s.dx; rs[k].dy <= w_s.dy;
                rs[k].dz <= w_s.dz;
                rs_a[k] <= w_a; rs_b[k] <= w_b;
                if (w_x >= w_r + BIT) begin
                    rs_x[k] <= w_x - (w_r + BIT);
                    rs_r[k] <= (w_r >> 1) + BIT;
                end else begin
                    rs_x[k] <= w_x;
                    rs_r[k] <= w_r >> 1;
                end
            end
        end
    end

    // stage 4: divider numerators
    t_side       r4;
    logic [61:0] r4_nx, r4_nz;
    logic [31:0] r4_root;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4.v <= 1'b0;
        else if (w_en) r4.v <= rs[SQ_LAST].v;
        if (w_en) begin
            r4.dx <= rs[SQ_LAST].dx; r4.dy <= rs[SQ_LAST].dy;
            r4.dz <= rs[SQ_LAST].dz;
            r4_nx <= 62'(r_rx * rs_a[SQ_LAST]);
            r4_nz <= 62'(r_rz * rs_b[SQ_LAST]);
            r4_root <= rs_r[SQ_LAST][31:0];
        end
    end

    logic        w_qv, w_qv_z;
    logic [31:0] w_qx, w_qz;
    tcsp_divider u_div_x (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r4.v),
        .i_num(r4_nx), .i_den(r4_root), .o_valid(w_qv), .o_quo(w_qx)
    );
    tcsp_divider u_div_z (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r4.v),
        .i_num(r4_nz), .i_den(r4_root), .o_valid(w_qv_z), .o_quo(w_qz)
    );

    // side data delay line matching the dividers
    t_side       rd    [tcsp_pkg::QUO_W];
    logic        rd_z  [tcsp_pkg::QUO_W];
    for (genvar k = 0; k < tcsp_pkg::QUO_W; k++) begin : g_dly
        t_side w_s;
        logic  w_z;
        if (k == 0) begin : g_src
            assign w_s = r4;
            assign w_z = (r4_root == '0);
        end else begin : g_src
            assign w_s = rd[k-1];
            assign w_z = rd_z[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                rd[k] <= w_s; rd_z[k] <= w_z;
            end
        end
    end

    // stage 5: signed ellipse point and top magnitudes
    t_side              r5;
    logic signed [32:0] r5_ex, r5_ez;
    logic [62:0]        r5_tmx, r5_tmz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5.v <= 1'b0;
        else if (w_en) r5.v <= w_qv;
        if (w_en) begin
            logic [31:0] qx, qz;
            qx = rd_z[DLY_LAST] ? '0 : w_qx;
            qz = rd_z[DLY_LAST] ? '0 : w_qz;
            r5.dx <= rd[DLY_LAST].dx; r5.dy <= rd[DLY_LAST].dy;
            r5.dz <= rd[DLY_LAST].dz;
            r5_ex <= rd[DLY_LAST].dx[31] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            r5_ez <= rd[DLY_LAST].dz[31] ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
            r5_tmx <= 63'(r_ratio * qx);
            r5_tmz <= 63'(r_ratio * qz);
        end
    end

    // stage 6: saturated top point
    t_side              r6;
    logic signed [31:0] r6_ex, r6_ez, r6_tx, r6_tz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6.v <= 1'b0;
        else if (w_en) r6.v <= r5.v;
        if (w_en) begin
            logic [62:0] mx, mz;
            mx = r5_tmx >> FRAC_BITS;
            mz = r5_tmz >> FRAC_BITS;
            r6.dx <= r5.dx; r6.dy <= r5.dy; r6.dz <= r5.dz;
            r6_ex <= r5_ex[31:0]; r6_ez <= r5_ez[31:0];
            if (r5_ex < 0) r6_tx <= (mx >= 63'h80000000) ? 32'sh80000000 : -$signed(mx[31:0]);
            else           r6_tx <= (mx >= 63'h7fffffff) ? 32'sh7fffffff : $signed(mx[31:0]);
            if (r5_ez < 0) r6_tz <= (mz >= 63'h80000000) ? 32'sh80000000 : -$signed(mz[31:0]);
            else           r6_tz <= (mz >= 63'h7fffffff) ? 32'sh7fffffff : $signed(mz[31:0]);
        end
    end

    // stage 7: difference products, top minus bottom per axis
    t_side              r7;
    logic signed [31:0] r7_ex, r7_ez, r7_tx, r7_tz;
    logic signed [65:0] r7_px, r7_pz;
    logic signed [63:0] r7_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7.v <= 1'b0;
        else if (w_en) r7.v <= r6.v;
        if (w_en) begin
            r7.dx <= r6.dx; r7.dy <= r6.dy; r7.dz <= r6.dz;
            r7_ex <= r6_ex; r7_ez <= r6_ez; r7_tx <= r6_tx; r7_tz <= r6_tz;
            r7_px <= 66'($signed(r6.dx) * (33'(r6_tx) - 33'(r6_ex)));
            r7_pz <= 66'($signed(r6.dz) * (33'(r6_tz) - 33'(r6_ez)));
            r7_py <= 64'($signed(r6.dy) * $signed({1'b0, r_hh}));
        end
    end

    // stage 8: compare and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (w_en) m_axis_tvalid <= r7.v;
        if (w_en) begin
            logic signed [67:0] diff;
            logic up;
            diff = 68'(r7_px) + 68'(r7_pz) + 68'(r7_py) + 68'(r7_py);
            up = (diff > 0);
            m_axis_tdata[31:0]  <= up ? r7_tx : r7_ex;
            m_axis_tdata[63:32] <= up ? {1'b0, r_hh} : -{1'b0, r_hh};
            m_axis_tdata[95:64] <= up ? r7_tz : r7_ez;
            m_axis_tuser        <= up;
        end
    end

    // both dividers run in lockstep
    a_div_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n) w_qv == w_qv_z)
        else $error("divider valid mismatch");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("result changed under stall");
    // input ready follows output space
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");
endmodule
